/* design/bdq_pkg.sv */
// Package with command, status and cell control codes for the bounded deque.
package bdq_pkg;

  localparam int unsigned DataWidth = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_TAIL = 3'd0,
    CMD_PUSH_HEAD = 3'd1,
    CMD_POP_TAIL  = 3'd2,
    CMD_POP_HEAD  = 3'd3,
    CMD_REMOVE    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD        = 2'd0,
    CELL_INSERT_HEAD = 2'd1,
    CELL_WRITE_AT    = 2'd2,
    CELL_CLOSE_AT    = 2'd3
  } cell_op_t;

endpackage

/* design/bdq_cell.sv */
// One storage cell of the deque chain, shifting with its neighbors.
module bdq_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned IW  = 4
) (
  input  logic                                 clk,
  input  bdq_pkg::cell_op_t                    op,
  input  logic [IW-1:0]                        idx,
  input  logic signed [bdq_pkg::DataWidth-1:0] value_in,
  input  logic signed [bdq_pkg::DataWidth-1:0] left_data,
  input  logic signed [bdq_pkg::DataWidth-1:0] right_data,
  output logic signed [bdq_pkg::DataWidth-1:0] data
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic signed [bdq_pkg::DataWidth-1:0] data_next;

  always_comb begin
    data_next = data;
    case (op)
      bdq_pkg::CELL_INSERT_HEAD: begin
        data_next = (MyIdx == '0) ? value_in : left_data;
      end
      bdq_pkg::CELL_WRITE_AT: begin
        if (MyIdx == idx) begin
          data_next = value_in;
        end
      end
      bdq_pkg::CELL_CLOSE_AT: begin
        if (MyIdx >= idx) begin
          data_next = right_data;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* design/bounded_deque_with_indexed_removal_core.sv */
// Top level of the bounded deque with removal by position.
// The list lives in a row of CAPACITY cells, entry 0 at the head; every cell moves
// in the same cycle for a push at either end, a pop or a removal at any position,
// so one item is accepted per cycle while the result register is free or being
// drained, and each result is registered in the cycle after its item is accepted.
// The longest path is the read of the removed entry, a CAPACITY-to-one selection.
module bounded_deque_with_indexed_removal_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           cmd,
  input  logic signed [bdq_pkg::DataWidth-1:0] value_in,
  input  logic [3:0]                           position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bdq_pkg::DataWidth-1:0] value_out,
  output logic [4:0]                           count_out,
  output logic [1:0]                           status
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;
  logic [31:0]   sel;
  logic [31:0]   count_wide;
  logic [31:0]   last_wide;
  logic [IW-1:0] idx;
  logic          take;
  logic [1:0]    status_next;

  bdq_pkg::cell_op_t op;

  logic signed [bdq_pkg::DataWidth-1:0] cells [CAPACITY];
  logic signed [bdq_pkg::DataWidth-1:0] rd_data;

  assign accept     = in_valid && in_ready;
  assign in_ready   = !out_valid || out_ready;
  assign full       = (count == CW'(CAPACITY));
  assign empty      = (count == '0);
  assign count_wide = 32'(count);
  assign last_wide  = count_wide - 32'd1;

  always_comb begin
    op          = bdq_pkg::CELL_HOLD;
    sel         = '0;
    take        = 1'b0;
    status_next = bdq_pkg::ST_OK;
    count_next  = count;
    case (cmd)
      bdq_pkg::CMD_PUSH_TAIL: begin
        if (full) begin
          status_next = bdq_pkg::ST_FULL;
        end else begin
          op         = bdq_pkg::CELL_WRITE_AT;
          sel        = count_wide;
          count_next = count + CW'(1);
        end
      end
      bdq_pkg::CMD_PUSH_HEAD: begin
        if (full) begin
          status_next = bdq_pkg::ST_FULL;
        end else begin
          op         = bdq_pkg::CELL_INSERT_HEAD;
          count_next = count + CW'(1);
        end
      end
      bdq_pkg::CMD_POP_TAIL, bdq_pkg::CMD_POP_HEAD, bdq_pkg::CMD_REMOVE: begin
        if (empty) begin
          status_next = bdq_pkg::ST_EMPTY;
        end else begin
          op         = bdq_pkg::CELL_CLOSE_AT;
          take       = 1'b1;
          count_next = count - CW'(1);
          if (cmd == bdq_pkg::CMD_POP_HEAD) begin
            sel = '0;
          end else if (cmd == bdq_pkg::CMD_REMOVE && 32'(position) < count_wide) begin
            sel = 32'(position);
          end else begin
            sel = last_wide;
          end
        end
      end
      default: begin
        op = bdq_pkg::CELL_HOLD;
      end
    endcase
  end

  assign idx     = sel[IW-1:0];
  assign rd_data = cells[idx];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [bdq_pkg::DataWidth-1:0] left_data;
    logic signed [bdq_pkg::DataWidth-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = value_in;
    end else begin : g_mid_left
      assign left_data = cells[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cells[i];
    end else begin : g_mid_right
      assign right_data = cells[i+1];
    end

    bdq_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk        (clk),
      .op         (accept ? op : bdq_pkg::CELL_HOLD),
      .idx        (idx),
      .value_in   (value_in),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  logic [31:0] count_next_wide;
  assign count_next_wide = 32'(count_next);

  always_ff @(posedge clk) begin
    if (accept) begin
      value_out <= take ? rd_data : '0;
      count_out <= count_next_wide[4:0];
      status    <= status_next;
    end
  end

endmodule
